/* hw/rtl/dit_pkg.sv */
package dit_pkg;

  localparam int BYTE_W    = 8;
  localparam int VALUE_W   = 16;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    ACT_DCS_SHORT = 4'd0,
    ACT_DCS_LONG  = 4'd1,
    ACT_GEN_SHORT = 4'd2,
    ACT_GEN_LONG  = 4'd3,
    ACT_DATA      = 4'd4,
    ACT_DELAY     = 4'd5,
    ACT_DCS_READ  = 4'd6,
    ACT_GEN_READ  = 4'd7,
    ACT_ERROR     = 4'd8,
    ACT_DONE      = 4'd9
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SEL_DCS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_GEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ    = 3'd4;

  localparam logic [BYTE_W-1:0] RST_SEL_DCS = 8'd0;
  localparam logic [BYTE_W-1:0] RST_SEL_GEN = 8'd1;
  localparam logic [BYTE_W-1:0] RST_WAIT    = 8'd2;
  localparam logic [BYTE_W-1:0] RST_WRITE   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_READ    = 8'd4;

  typedef struct packed {
    action_t              action;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   byte_count;
    logic                 truncated;
    logic                 last_of_run;
  } result_t;

endpackage

/* hw/rtl/dit_ifs.sv */
interface dit_script_if;
  logic                        valid;
  logic                        ready;
  logic [dit_pkg::BYTE_W-1:0]  script_byte;
  logic                        script_start;

  modport source (output valid, script_byte, script_start, input ready);
  modport sink   (input valid, script_byte, script_start, output ready);
endinterface

interface dit_result_if;
  logic                         valid;
  logic                         ready;
  dit_pkg::action_t             action;
  logic [dit_pkg::VALUE_W-1:0]  value;
  logic [dit_pkg::COUNT_W-1:0]  byte_count;
  logic                         truncated;
  logic                         last_of_run;

  modport source (output valid, action, value, byte_count, truncated, last_of_run,
                  input ready);
  modport sink   (input valid, action, value, byte_count, truncated, last_of_run,
                  output ready);
endinterface

/* hw/rtl/display_init_script_interpreter.sv */
// channel   dir   beat contents
// in_ch     in    script_byte, script_start
// out_ch    out   action, value, byte_count, truncated, last_of_run
// cfg_*     in    cfg_we, cfg_index, cfg_data (opcode byte registers)
//
// one script byte is taken per cycle while in_ch.ready is high; the parse state updates at that edge
// and its zero, one or two results land in a four-entry result queue
// in_ch.ready is high while the queue has room for two results
// a byte that yields two results holds the output for two beats
// synchronous active-low reset returns to idle and empties the queue
module display_init_script_interpreter (
  input  logic                           clk,
  input  logic                           rst_n,
  dit_script_if.sink                     in_ch,
  dit_result_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [dit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dit_pkg::BYTE_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_LEN_LO, PH_OPCODE, PH_WAIT_HI, PH_WAIT_LO,
    PH_WRITE_LEN, PH_WRITE_DATA, PH_READ_REG, PH_READ_CNT
  } phase_t;

  typedef enum logic [1:0] {
    PKT_NONE, PKT_DCS, PKT_GEN
  } pkt_t;

  logic [dit_pkg::BYTE_W-1:0]  code_dcs_r, code_gen_r, code_wait_r, code_write_r, code_read_r;

  phase_t                       phase_r, phase_nxt;
  pkt_t                         pkt_r, pkt_nxt;
  logic [dit_pkg::VALUE_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [dit_pkg::BYTE_W-1:0]   header_high_r, header_high_nxt;
  logic [dit_pkg::COUNT_W-1:0]  args_left_r, args_left_nxt;
  logic [dit_pkg::VALUE_W-1:0]  arg_accum_r, arg_accum_nxt;
  logic                         aborted_r, aborted_nxt;

  dit_pkg::result_t             queue_r [dit_pkg::QDEPTH];
  logic [dit_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [dit_pkg::QCNT_W-1:0]   cnt_r;

  logic                         in_acc, out_pop;
  logic [dit_pkg::BYTE_W-1:0]   b;
  logic                         body_v, done_v, done_trunc;
  dit_pkg::result_t             body_res, done_res, ent0, ent1;
  logic [1:0]                   n_push;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_pop = out_ch.valid && out_ch.ready;
  assign b       = in_ch.script_byte;

  always_comb begin
    phase_nxt       = phase_r;
    pkt_nxt         = pkt_r;
    bytes_left_nxt  = bytes_left_r;
    header_high_nxt = header_high_r;
    args_left_nxt   = args_left_r;
    arg_accum_nxt   = arg_accum_r;
    aborted_nxt     = aborted_r;
    body_v          = 1'b0;
    body_res        = '0;
    done_v          = 1'b0;
    done_trunc      = 1'b0;
    if (in_acc) begin
      if (in_ch.script_start) begin
        header_high_nxt = b;
        phase_nxt       = PH_LEN_LO;
        pkt_nxt         = PKT_NONE;
        bytes_left_nxt  = '0;
        args_left_nxt   = '0;
        arg_accum_nxt   = '0;
        aborted_nxt     = 1'b0;
      end else begin
        case (phase_r)
          PH_IDLE: begin
          end
          PH_LEN_LO: begin
            bytes_left_nxt = {header_high_r, b};
            phase_nxt      = PH_OPCODE;
            if ({header_high_r, b} == '0) begin
              done_v    = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            if (!aborted_r) begin
              case (phase_r)
                PH_OPCODE: begin
                  if (b == code_dcs_r) begin
                    pkt_nxt = PKT_DCS;
                  end else if (b == code_gen_r) begin
                    pkt_nxt = PKT_GEN;
                  end else if (b == code_wait_r) begin
                    phase_nxt = PH_WAIT_HI;
                  end else if (b == code_write_r) begin
                    if (pkt_r == PKT_NONE) begin
                      body_v          = 1'b1;
                      body_res.action = dit_pkg::ACT_ERROR;
                      aborted_nxt     = 1'b1;
                    end else begin
                      phase_nxt = PH_WRITE_LEN;
                    end
                  end else if (b == code_read_r) begin
                    phase_nxt = PH_READ_REG;
                  end
                end
                PH_WAIT_HI: begin
                  arg_accum_nxt = {b, 8'd0};
                  phase_nxt     = PH_WAIT_LO;
                end
                PH_WAIT_LO: begin
                  arg_accum_nxt   = {arg_accum_r[15:8], b};
                  body_v          = 1'b1;
                  body_res.action = dit_pkg::ACT_DELAY;
                  body_res.value  = {arg_accum_r[15:8], b};
                  phase_nxt       = PH_OPCODE;
                end
                PH_WRITE_LEN: begin
                  body_v = 1'b1;
                  if (pkt_r == PKT_DCS) begin
                    body_res.action = (b == 8'd1) ? dit_pkg::ACT_DCS_SHORT
                                                  : dit_pkg::ACT_DCS_LONG;
                  end else begin
                    body_res.action = (b == 8'd1) ? dit_pkg::ACT_GEN_SHORT
                                                  : dit_pkg::ACT_GEN_LONG;
                  end
                  body_res.byte_count = b;
                  args_left_nxt       = b;
                  phase_nxt           = (b != '0) ? PH_WRITE_DATA : PH_OPCODE;
                end
                PH_WRITE_DATA: begin
                  body_v          = 1'b1;
                  body_res.action = dit_pkg::ACT_DATA;
                  body_res.value  = {8'd0, b};
                  args_left_nxt   = args_left_r - 8'd1;
                  if (args_left_r == 8'd1) begin
                    phase_nxt = PH_OPCODE;
                  end
                end
                PH_READ_REG: begin
                  arg_accum_nxt = {8'd0, b};
                  phase_nxt     = PH_READ_CNT;
                end
                PH_READ_CNT: begin
                  body_res.value      = {8'd0, arg_accum_r[7:0]};
                  body_res.byte_count = b;
                  if (pkt_r == PKT_DCS) begin
                    body_v          = 1'b1;
                    body_res.action = dit_pkg::ACT_DCS_READ;
                  end else if (pkt_r == PKT_GEN) begin
                    body_v          = 1'b1;
                    body_res.action = dit_pkg::ACT_GEN_READ;
                  end
                  phase_nxt = PH_OPCODE;
                end
                default: begin
                end
              endcase
            end
            bytes_left_nxt = bytes_left_r - 16'd1;
            if (bytes_left_r == 16'd1) begin
              done_v     = 1'b1;
              done_trunc = !aborted_nxt && (phase_nxt != PH_OPCODE);
              phase_nxt  = PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    done_res           = '0;
    done_res.action    = dit_pkg::ACT_DONE;
    done_res.truncated = done_trunc;
    done_res.last_of_run = 1'b1;
    ent0             = body_v ? body_res : done_res;
    ent0.last_of_run = !(body_v && done_v);
    ent1             = done_res;
    n_push           = {1'b0, body_v} + {1'b0, done_v};
  end

  assign in_ch.ready        = (cnt_r <= dit_pkg::QCNT_W'(dit_pkg::QDEPTH - 2));
  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.action      = queue_r[rd_ptr_r].action;
  assign out_ch.value       = queue_r[rd_ptr_r].value;
  assign out_ch.byte_count  = queue_r[rd_ptr_r].byte_count;
  assign out_ch.truncated   = queue_r[rd_ptr_r].truncated;
  assign out_ch.last_of_run = queue_r[rd_ptr_r].last_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_dcs_r    <= dit_pkg::RST_SEL_DCS;
      code_gen_r    <= dit_pkg::RST_SEL_GEN;
      code_wait_r   <= dit_pkg::RST_WAIT;
      code_write_r  <= dit_pkg::RST_WRITE;
      code_read_r   <= dit_pkg::RST_READ;
      phase_r       <= PH_IDLE;
      pkt_r         <= PKT_NONE;
      bytes_left_r  <= '0;
      header_high_r <= '0;
      args_left_r   <= '0;
      arg_accum_r   <= '0;
      aborted_r     <= 1'b0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dit_pkg::CFG_SEL_DCS: code_dcs_r   <= cfg_data;
          dit_pkg::CFG_SEL_GEN: code_gen_r   <= cfg_data;
          dit_pkg::CFG_WAIT:    code_wait_r  <= cfg_data;
          dit_pkg::CFG_WRITE:   code_write_r <= cfg_data;
          dit_pkg::CFG_READ:    code_read_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      phase_r       <= phase_nxt;
      pkt_r         <= pkt_nxt;
      bytes_left_r  <= bytes_left_nxt;
      header_high_r <= header_high_nxt;
      args_left_r   <= args_left_nxt;
      arg_accum_r   <= arg_accum_nxt;
      aborted_r     <= aborted_nxt;
      wr_ptr_r      <= wr_ptr_r + dit_pkg::QPTR_W'(n_push);
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + dit_pkg::QCNT_W'(n_push) - dit_pkg::QCNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= ent0;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_r + 1'b1] <= ent1;
    end
  end

endmodule

/* hw/rtl/dit_checker.sv */
module dit_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  dit_pkg::action_t               out_action,
  input  logic [dit_pkg::COUNT_W-1:0]    out_byte_count,
  input  logic                           out_truncated,
  input  logic                           out_last_of_run
);

  // a stalled beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == dit_pkg::ACT_DONE |-> out_last_of_run)
    else $error("done beat not last of its run");

  a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_action == dit_pkg::ACT_DONE
      && out_byte_count == '0)
    else $error("truncated flag on a non-done beat");

endmodule

bind display_init_script_interpreter dit_checker u_dit_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_action      (out_ch.action),
  .out_byte_count  (out_ch.byte_count),
  .out_truncated   (out_ch.truncated),
  .out_last_of_run (out_ch.last_of_run)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import dit_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LEN_LO, PH_OPCODE, PH_WAIT_HI, PH_WAIT_LO,
    PH_WR_LEN, PH_WR_DATA, PH_RD_REG, PH_RD_CNT
  } parse_phase_e;

  typedef enum logic [1:0] {PT_NONE, PT_DCS, PT_GEN} packet_type_e;

  typedef logic [7:0] bytes_t[$];

  class init_script_checker;
    logic [7:0]   code_dcs, code_gen, code_wait, code_write, code_read;
    parse_phase_e phase;
    packet_type_e ptype;
    logic [15:0]  bytes_left;
    logic [7:0]   len_high;
    logic [7:0]   args_left;
    logic [15:0]  accum;
    bit           aborted;
    result_t      due_results[$];
    int           mismatches;

    function new();
      code_dcs   = RST_SEL_DCS;
      code_gen   = RST_SEL_GEN;
      code_wait  = RST_WAIT;
      code_write = RST_WRITE;
      code_read  = RST_READ;
      phase      = PH_IDLE;
      ptype      = PT_NONE;
      bytes_left = '0;
      len_high   = '0;
      args_left  = '0;
      accum      = '0;
      aborted    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_code(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_SEL_DCS: code_dcs = val;
        CFG_SEL_GEN: code_gen = val;
        CFG_WAIT:    code_wait = val;
        CFG_WRITE:   code_write = val;
        CFG_READ:    code_read = val;
        default: ;
      endcase
    endfunction

    function void queue_result(action_t act, logic [15:0] val, logic [7:0] cnt, logic trunc);
      result_t r;
      r.action      = act;
      r.value       = val;
      r.byte_count  = cnt;
      r.truncated   = trunc;
      r.last_of_run = 1'b0;
      due_results.push_back(r);
    endfunction

    function void parse_body(logic [7:0] b);
      action_t act;
      case (phase)
        PH_OPCODE: begin
          if (b == code_dcs) ptype = PT_DCS;
          else if (b == code_gen) ptype = PT_GEN;
          else if (b == code_wait) phase = PH_WAIT_HI;
          else if (b == code_write) begin
            if (ptype == PT_NONE) begin
              queue_result(ACT_ERROR, 16'h0, 8'h0, 1'b0);
              aborted = 1'b1;
            end else begin
              phase = PH_WR_LEN;
            end
          end else if (b == code_read) phase = PH_RD_REG;
        end
        PH_WAIT_HI: begin
          accum = {b, 8'h00};
          phase = PH_WAIT_LO;
        end
        PH_WAIT_LO: begin
          accum = {accum[15:8], b};
          queue_result(ACT_DELAY, accum, 8'h0, 1'b0);
          phase = PH_OPCODE;
        end
        PH_WR_LEN: begin
          if (ptype == PT_DCS) act = (b == 8'd1) ? ACT_DCS_SHORT : ACT_DCS_LONG;
          else act = (b == 8'd1) ? ACT_GEN_SHORT : ACT_GEN_LONG;
          queue_result(act, 16'h0, b, 1'b0);
          args_left = b;
          phase = (b != 8'd0) ? PH_WR_DATA : PH_OPCODE;
        end
        PH_WR_DATA: begin
          queue_result(ACT_DATA, {8'h00, b}, 8'h0, 1'b0);
          args_left = args_left - 8'd1;
          if (args_left == 8'd0) phase = PH_OPCODE;
        end
        PH_RD_REG: begin
          accum = {8'h00, b};
          phase = PH_RD_CNT;
        end
        PH_RD_CNT: begin
          if (ptype == PT_DCS) queue_result(ACT_DCS_READ, {8'h00, accum[7:0]}, b, 1'b0);
          else if (ptype == PT_GEN) queue_result(ACT_GEN_READ, {8'h00, accum[7:0]}, b, 1'b0);
          phase = PH_OPCODE;
        end
        default: ;
      endcase
    endfunction

    function void interpret_beat(logic [7:0] b, logic start);
      int      n_prior;
      result_t r;
      if (start) begin
        len_high   = b;
        phase      = PH_LEN_LO;
        ptype      = PT_NONE;
        bytes_left = '0;
        args_left  = '0;
        accum      = '0;
        aborted    = 1'b0;
        return;
      end
      if (phase == PH_IDLE) return;
      n_prior = due_results.size();
      if (phase == PH_LEN_LO) begin
        bytes_left = {len_high, b};
        phase = PH_OPCODE;
        if (bytes_left == 16'd0) begin
          queue_result(ACT_DONE, 16'h0, 8'h0, 1'b0);
          phase = PH_IDLE;
        end
      end else begin
        if (!aborted) parse_body(b);
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin
          queue_result(ACT_DONE, 16'h0, 8'h0, !aborted && phase != PH_OPCODE);
          phase = PH_IDLE;
        end
      end
      if (due_results.size() > n_prior) begin
        r = due_results.pop_back();
        r.last_of_run = 1'b1;
        due_results.push_back(r);
      end
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result action=%0d value=%h", got.action, got.value));
        return;
      end
      want = due_results.pop_front();
      if (got.action !== want.action)
        report($sformatf("action %0d, expected %0d", got.action, want.action));
      if (got.value !== want.value)
        report($sformatf("value %h, expected %h (action %0d)", got.value, want.value,
                         want.action));
      if (got.byte_count !== want.byte_count)
        report($sformatf("byte_count %h, expected %h (action %0d)", got.byte_count,
                         want.byte_count, want.action));
      if (got.truncated !== want.truncated)
        report($sformatf("truncated %b, expected %b (action %0d)", got.truncated,
                         want.truncated, want.action));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %b, expected %b (action %0d)", got.last_of_run,
                         want.last_of_run, want.action));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  dit_script_if in_ch();
  dit_result_if out_ch();

  display_init_script_interpreter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  init_script_checker sb;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      beats_sent = 0;
  int      quiet_cycles = 0;
  result_t got_beat;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample both channels on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.interpret_beat(in_ch.script_byte, in_ch.script_start);
      if (out_ch.valid && out_ch.ready) begin
        got_beat.action      = out_ch.action;
        got_beat.value       = out_ch.value;
        got_beat.byte_count  = out_ch.byte_count;
        got_beat.truncated   = out_ch.truncated;
        got_beat.last_of_run = out_ch.last_of_run;
        sb.check_result(got_beat);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.script_byte  <= b;
    in_ch.script_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_framed(input logic [15:0] len, input bytes_t body, input bit noisy);
    send_beat(len[15:8], 1'b1);
    send_beat(len[7:0], 1'b0);
    foreach (body[i]) begin
      // occasional restart in the middle of a script
      if (noisy && $urandom_range(199) == 0) send_beat(8'($urandom_range(255)), 1'b1);
      send_beat(body[i], 1'b0);
    end
  endtask

  function automatic bytes_t random_body();
    bytes_t q;
    int     n_cmds;
    int     pick;
    int     n;
    n_cmds = $urandom_range(1, 8);
    if ($urandom_range(99) < 85) q.push_back($urandom_range(1) ? sb.code_dcs : sb.code_gen);
    repeat (n_cmds) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        q.push_back($urandom_range(1) ? sb.code_dcs : sb.code_gen);
      end else if (pick < 25) begin
        q.push_back(sb.code_wait);
        q.push_back(8'($urandom_range(255)));
        q.push_back(8'($urandom_range(255)));
      end else if (pick < 65) begin
        n = ($urandom_range(99) < 2) ? $urandom_range(5, 255) : $urandom_range(4);
        q.push_back(sb.code_write);
        q.push_back(8'(n));
        repeat (n) q.push_back(8'($urandom_range(255)));
      end else if (pick < 88) begin
        q.push_back(sb.code_read);
        q.push_back(8'($urandom_range(255)));
        q.push_back(8'($urandom_range(255)));
      end else begin
        q.push_back(8'($urandom_range(255)));
      end
    end
    return q;
  endfunction

  task automatic send_random_script();
    bytes_t      body;
    logic [15:0] len;
    int          mode;
    body = random_body();
    len  = 16'(body.size());
    mode = $urandom_range(99);
    if (mode < 8) len = 16'($urandom_range(0, body.size() - 1));
    else if (mode < 12) len = 16'($urandom_range(65535));
    else if (mode < 15) len = len + 16'($urandom_range(1, 3));
    send_framed(len, body, 1'b1);
    // stray bytes after the script ends
    if ($urandom_range(99) < 5) repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_code(idx, val);
  endtask

  task automatic write_codes(input logic [7:0] dcs, input logic [7:0] gen, input logic [7:0] wt,
                             input logic [7:0] wr, input logic [7:0] rd);
    write_reg(CFG_SEL_DCS, dcs);
    write_reg(CFG_SEL_GEN, gen);
    write_reg(CFG_WAIT, wt);
    write_reg(CFG_WRITE, wr);
    write_reg(CFG_READ, rd);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input int n_beats);
    int target;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    target        = beats_sent + n_beats;
    while (beats_sent < target) send_random_script();
    drain();
  endtask

  initial begin
    logic [7:0] base;
    sb = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.script_byte  <= '0;
    in_ch.script_start <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero length, a byte while idle, then a restart that drops the type
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h09, 1'b0);
    send_beat(RST_SEL_GEN, 1'b0);
    // read and write with no type selected
    send_framed(16'd4, '{RST_READ, 8'h10, 8'h02, RST_WRITE}, 1'b0);
    // short write, then body runs out inside a read
    send_framed(16'd7, '{RST_SEL_DCS, RST_WRITE, 8'h01, 8'hFF, RST_SEL_GEN, RST_READ, 8'hFE},
                1'b0);
    // max delay, unknown opcode, error on the final body beat
    send_framed(16'd5, '{RST_WAIT, 8'hFF, 8'hFF, 8'h77, RST_WRITE}, 1'b0);
    drain();

    run_phase(0, 0, 170);

    write_codes(8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h00);
    run_phase(72, 0, 170);

    base = 8'($urandom_range(255));
    write_codes(base, base + 8'd37, base + 8'd74, base + 8'd111, base + 8'd148);
    run_phase(0, 72, 170);

    // shared opcode values: first match wins
    base = 8'($urandom_range(255));
    write_codes(base, base + 8'd1, base, base + 8'd2, base + 8'd2);
    run_phase(12, 12, 170);

    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
